@@ design/sam_pkg.sv @@
// Shared types and constants for the signal activity monitor.
// Holds the request and response beat layouts carried on the stream interface
// and used by the top level. Depends on nothing.
package sam_pkg;

   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned COUNT_OUT_W = 32;

   typedef struct packed {
      logic        [INDEX_W-1:0] signal_index;
      logic signed [VALUE_W-1:0] sample_value;
      logic        [TIME_W-1:0]  sample_time;
   } req_payload_type;

   typedef struct packed {
      logic        [INDEX_W-1:0]     entry_index;
      logic        [COUNT_OUT_W-1:0] toggle_total;
      logic        [COUNT_OUT_W-1:0] change_total;
      logic signed [VALUE_W-1:0]     lowest_value;
      logic signed [VALUE_W-1:0]     highest_value;
      logic        [VALUE_W-1:0]     bits_changed;
      logic        [VALUE_W-1:0]     bits_touched;
      logic        [TIME_W-1:0]      earliest_time;
      logic        [TIME_W-1:0]      latest_time;
      logic                          toggled_now;
   } rsp_payload_type;

endpackage

@@ design/sam_stream_if.sv @@
// Valid/ready stream interface carrying one payload per beat.
// The payload type is a parameter; the monitor uses the beat layouts
// from sam_pkg.
interface sam_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/signal_activity_monitor_unit.sv @@
// Signal activity monitor top level: a per-signal statistics table with a
// two-stage read-update-write pipeline. Depends on sam_pkg and sam_stream_if.
//
// Each request beat is one value change of a traced signal. The block reads
// that signal's table entry, updates its sample and toggle counts, signed
// minimum and maximum, bit activity masks and first and last timestamps, writes
// the entry back and returns the updated entry as one response beat. One beat
// is taken per cycle unless the output stalls; the response is registered.
// The rate is set by the single read and single write port of the table, and
// back-to-back beats on the same signal are forwarded around the table. After
// reset the table is cleared one entry per cycle, with req.ready low until it
// is done. Indexes of NUM_SIGNALS or more wrap modulo NUM_SIGNALS.
module signal_activity_monitor_unit
   import sam_pkg::*;
#(
   parameter int unsigned NUM_SIGNALS = 256,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   sam_stream_if.sink   req,
   sam_stream_if.source rsp
);

   localparam int unsigned IDX_W = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SIGNALS - 1);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [VALUE_W-1:0] SIGNED_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] SIGNED_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] toggle_count;
      logic [COUNT_WIDTH-1:0] change_count;
      logic [VALUE_W-1:0]     min_value;
      logic [VALUE_W-1:0]     max_value;
      logic [VALUE_W-1:0]     ones_seen;
      logic [VALUE_W-1:0]     zeros_seen;
      logic [VALUE_W-1:0]     previous_value;
      logic [TIME_W-1:0]      first_time;
      logic [TIME_W-1:0]      last_time;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{
      toggle_count:   '0,
      change_count:   '0,
      min_value:      SIGNED_MAX,
      max_value:      SIGNED_MIN,
      ones_seen:      '0,
      zeros_seen:     '0,
      previous_value: '0,
      first_time:     '0,
      last_time:      '0
   };

   entry_type mem [NUM_SIGNALS];

   logic              clear_ff;
   logic [IDX_W-1:0]  clear_idx_ff;
   logic              s1_valid_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic [TIME_W-1:0] s1_time_ff;
   entry_type         rd_data_ff;
   logic              fwd_ff;
   entry_type         fwd_data_ff;
   logic              out_valid_ff;
   rsp_payload_type   rsp_ff;

   logic              accept;
   logic              commit;
   logic [IDX_W-1:0]  req_idx;
   entry_type         cur_entry;
   entry_type         entry_in;
   logic              toggled_in;
   logic              seen;
   rsp_payload_type   rsp_in;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;

   // Reduce the incoming index modulo the table depth.
   generate
      if (NUM_SIGNALS >= 256) begin : g_idx_direct
         assign req_idx = IDX_W'(req.payload.signal_index);
      end else begin : g_idx_mod
         localparam logic [16:0] RECIP = 17'((65536 + NUM_SIGNALS - 1) / NUM_SIGNALS);
         localparam logic [15:0] DEPTH = 16'(NUM_SIGNALS);
         logic [24:0] prod;
         logic [7:0]  quot;
         logic [15:0] rem;
         logic [15:0] rem_fix;
         always_comb begin
            prod = 25'(req.payload.signal_index) * 25'(RECIP);
            quot = prod[23:16];
            rem  = 16'(req.payload.signal_index) - 16'(quot) * DEPTH;
            rem_fix = (rem >= DEPTH) ? rem - DEPTH : rem;
         end
         assign req_idx = IDX_W'(rem_fix);
      end
   endgenerate

   assign commit    = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !clear_ff && (!s1_valid_ff || commit);
   assign accept    = req.valid && req.ready;

   assign cur_entry = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign seen      = cur_entry.change_count != '0;

   always_comb begin
      entry_in   = cur_entry;
      toggled_in = 1'b0;
      entry_in.change_count = (cur_entry.change_count == CNT_MAX) ?
                              CNT_MAX : cur_entry.change_count + 1'b1;
      if ($signed(s1_value_ff) < $signed(cur_entry.min_value)) begin
         entry_in.min_value = s1_value_ff;
      end
      if ($signed(cur_entry.max_value) < $signed(s1_value_ff)) begin
         entry_in.max_value = s1_value_ff;
      end
      entry_in.ones_seen  = cur_entry.ones_seen | s1_value_ff;
      entry_in.zeros_seen = cur_entry.zeros_seen | ~s1_value_ff;
      if (!seen) begin
         entry_in.previous_value = s1_value_ff;
         entry_in.first_time     = s1_time_ff;
         entry_in.last_time      = s1_time_ff;
      end else begin
         if (cur_entry.previous_value != s1_value_ff) begin
            toggled_in = 1'b1;
            entry_in.toggle_count = (cur_entry.toggle_count == CNT_MAX) ?
                                    CNT_MAX : cur_entry.toggle_count + 1'b1;
            entry_in.previous_value = s1_value_ff;
         end
         if (s1_time_ff < cur_entry.first_time) begin
            entry_in.first_time = s1_time_ff;
         end
         if (s1_time_ff > cur_entry.last_time) begin
            entry_in.last_time = s1_time_ff;
         end
      end
   end

   always_comb begin
      rsp_in.entry_index   = INDEX_W'(s1_idx_ff);
      rsp_in.toggle_total  = COUNT_OUT_W'(entry_in.toggle_count);
      rsp_in.change_total  = COUNT_OUT_W'(entry_in.change_count);
      rsp_in.lowest_value  = entry_in.min_value;
      rsp_in.highest_value = entry_in.max_value;
      rsp_in.bits_changed  = entry_in.ones_seen & entry_in.zeros_seen;
      rsp_in.bits_touched  = entry_in.ones_seen | entry_in.zeros_seen;
      rsp_in.earliest_time = entry_in.first_time;
      rsp_in.latest_time   = entry_in.last_time;
      rsp_in.toggled_now   = toggled_in;
   end

   assign mem_we    = clear_ff || commit;
   assign mem_waddr = clear_ff ? clear_idx_ff : s1_idx_ff;
   assign mem_wdata = clear_ff ? RESET_ENTRY : entry_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_idx_ff <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (clear_ff) begin
            clear_idx_ff <= clear_idx_ff + 1'b1;
            if (clear_idx_ff == LAST_IDX) begin
               clear_ff <= 1'b0;
            end
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= commit && (s1_idx_ff == req_idx);
         end else if (commit) begin
            s1_valid_ff <= 1'b0;
         end
         if (commit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= req_idx;
         s1_value_ff <= req.payload.sample_value;
         s1_time_ff  <= req.payload.sample_time;
         fwd_data_ff <= entry_in;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = rsp_ff;

endmodule
